FILE: hw/rtl/fcbr_pkg.sv
// ----------------------------------------------------------------------------
// Freezer cartridge bus responder package
// Shared types, codes and reset constants of the cartridge bus responder.
// ----------------------------------------------------------------------------
`default_nettype none

package fcbr_pkg;

	localparam int unsigned BANK_BYTES_DEF = 8192;
	localparam int unsigned ROM_BANKS_DEF  = 4;

	localparam logic [19:0] DEBOUNCE_RST = 20'd500000;
	localparam logic [2:0]  RUN_RST      = 3'd3;
	localparam logic [2:0]  RUN_MAX      = 3'd7;
	localparam logic [7:0]  CTRL_FROZEN  = 8'd3;

	localparam int unsigned CFG_DATA_W = 20;

	typedef enum logic [0:0] {
		CFG_DEBOUNCE_CYCLES  = 1'b0,
		CFG_FREEZE_WRITE_RUN = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_LOAD  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	localparam logic [2:0] REG_NONE = 3'd0;
	localparam logic [2:0] REG_ROML = 3'd1;
	localparam logic [2:0] REG_ROMH = 3'd2;
	localparam logic [2:0] REG_IO1  = 3'd3;
	localparam logic [2:0] REG_IO2  = 3'd4;

	localparam int unsigned CTRL_DISABLE_BIT = 2;
	localparam int unsigned CTRL_BANK_LSB    = 3;
	localparam int unsigned CTRL_RAM_BIT     = 5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [14:0] addr;
		logic [2:0]  region;
		logic [7:0]  write_data;
		logic        freeze_button;
	} in_t;

	typedef struct packed {
		logic       drive_bus;
		logic [7:0] read_data;
		logic       game_low;
		logic       exrom_high;
		logic       nmi_low;
		logic       led_on;
	} out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fcbr_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/freezer_cartridge_bus_responder.sv
// ----------------------------------------------------------------------------
// Freezer cartridge bus responder
// Answers host bus cycles from a banked ROM, a RAM and a control byte, and
// runs the freeze button, NMI and ultimax logic.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one host bus cycle or one ROM image
// load; each produces exactly one transfer on the output channel carrying the
// read data and the GAME, EXROM, NMI and LED levels after that cycle.
// One item is taken every clock cycle unless the output stalls or the RAM is
// being cleared. The RAM and ROM are read in the cycle of acceptance and their
// registered data are passed on to the output register. Control state is updated at
// acceptance, so a following item sees it at once.
// When the receiver stalls, one result waits in the output register and one
// more in the read stage; the input is held off when both are full and
// during the RAM clearing pass. After reset the RAM is cleared one byte per
// cycle; no input is taken during that pass, while configuration writes are
// taken throughout. The ROM image is kept across reset.
// ----------------------------------------------------------------------------
`default_nettype none

module freezer_cartridge_bus_responder #(
	parameter int unsigned BANK_BYTES = fcbr_pkg::BANK_BYTES_DEF,
	parameter int unsigned ROM_BANKS  = fcbr_pkg::ROM_BANKS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire fcbr_pkg::cfg_idx_t              cfg_index,
	input  wire logic [fcbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire fcbr_pkg::in_t                   in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output fcbr_pkg::out_t                       out_data
);

	localparam int unsigned ROM_BYTES = BANK_BYTES * ROM_BANKS;
	localparam int unsigned RAM_AW    = $clog2(BANK_BYTES);
	localparam int unsigned ROM_AW    = $clog2(ROM_BYTES);
	localparam int unsigned ADDR_W    = 15;
	localparam int unsigned WIDE_W    = 26;

	typedef enum logic [1:0] {
		SEL_NONE,
		SEL_ROM,
		SEL_RAM,
		SEL_CTRL
	} sel_t;

	// Reduction by a constant modulus through eight compare and subtract steps.
	function automatic logic [ADDR_W-1:0] wrap_mod(input logic [ADDR_W-1:0] x,
			input int unsigned m);
		logic [WIDE_W-1:0] r;
		logic [WIDE_W-1:0] s;
		r = WIDE_W'(x);
		for (int k = 7; k >= 0; k--) begin
			s = WIDE_W'(m) << k;
			if (r >= s) begin
				r = r - s;
			end
		end
		return ADDR_W'(r);
	endfunction

	logic [19:0] debounce_cycles_q;
	logic [2:0]  freeze_write_run_q;

	logic [7:0]  ctrl_q;
	logic        cart_en_q;
	logic        ram_map_q;
	logic [1:0]  bank_q;
	logic [2:0]  run_cnt_q;
	logic [19:0] deb_left_q;
	logic        pend_q;
	logic        nmi_q;
	logic        led_q;

	logic [7:0]  ctrl_d;
	logic        cart_en_d;
	logic        ram_map_d;
	logic [1:0]  bank_d;
	logic [2:0]  run_cnt_d;
	logic [19:0] deb_left_d;
	logic        pend_d;
	logic        nmi_d;
	logic        led_d;

	logic              clearing_q;
	logic [RAM_AW-1:0] clr_idx_q;

	logic        v_s1;
	sel_t        sel_s1;
	logic [7:0]  ctrl_s1;
	logic [3:0]  lvl_s1;
	logic        out_v_q;
	fcbr_pkg::out_t out_q;

	logic        accept;
	logic        s1_adv;
	logic        is_bus;
	logic        is_wr;
	logic        served;
	sel_t        sel_d;
	logic [ADDR_W-1:0] off_w;
	logic [ADDR_W-1:0] bank_w;
	logic [ADDR_W-1:0] load_w;
	logic [RAM_AW-1:0] off;
	logic [ROM_AW-1:0] rom_rd_addr;

	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [7:0]        ram_rdata;
	logic              rom_we;
	logic              rom_re;
	logic [7:0]        rom_rdata;

	assign s1_adv   = v_s1 && (!out_v_q || out_ready);
	assign in_ready = !clearing_q && (!v_s1 || s1_adv);
	assign accept   = in_valid && in_ready;

	assign is_bus = (in_data.req_type == fcbr_pkg::REQ_READ)
		|| (in_data.req_type == fcbr_pkg::REQ_WRITE);
	assign is_wr  = in_data.req_type == fcbr_pkg::REQ_WRITE;

	assign off_w       = wrap_mod({2'b00, in_data.addr[12:0]}, BANK_BYTES);
	assign off         = RAM_AW'(off_w);
	assign bank_w      = wrap_mod(ADDR_W'(bank_q), ROM_BANKS);
	assign rom_rd_addr = ROM_AW'(bank_w * BANK_BYTES) + ROM_AW'(off_w);
	assign load_w      = wrap_mod(in_data.addr, ROM_BYTES);

	always_comb begin
		ctrl_d     = ctrl_q;
		cart_en_d  = cart_en_q;
		ram_map_d  = ram_map_q;
		bank_d     = bank_q;
		run_cnt_d  = run_cnt_q;
		deb_left_d = deb_left_q;
		pend_d     = pend_q;
		nmi_d      = nmi_q;
		led_d      = led_q;
		sel_d      = SEL_NONE;
		served     = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = off;
		ram_wdata  = in_data.write_data;
		ram_re     = 1'b0;
		rom_re     = 1'b0;
		rom_we     = accept && (in_data.req_type == fcbr_pkg::REQ_LOAD);

		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = 8'd0;
		end

		if (accept && is_bus) begin
			if (is_wr) begin
				if (run_cnt_q < fcbr_pkg::RUN_MAX) begin
					run_cnt_d = run_cnt_q + 3'd1;
				end
			end else begin
				run_cnt_d = 3'd0;
			end

			if (cart_en_q) begin
				served = 1'b1;
				priority if (!is_wr && ((in_data.region == fcbr_pkg::REG_ROML && !ram_map_q)
						|| in_data.region == fcbr_pkg::REG_ROMH)) begin
					sel_d  = SEL_ROM;
					rom_re = 1'b1;
				end else if (!is_wr && in_data.region == fcbr_pkg::REG_ROML) begin
					sel_d  = SEL_RAM;
					ram_re = 1'b1;
				end else if (is_wr && in_data.region == fcbr_pkg::REG_ROML && ram_map_q) begin
					ram_we = 1'b1;
				end else if (!is_wr && in_data.region == fcbr_pkg::REG_IO1) begin
					sel_d = SEL_CTRL;
				end else if (!is_wr && in_data.region == fcbr_pkg::REG_IO2) begin
					if (ram_map_q) begin
						sel_d  = SEL_RAM;
						ram_re = 1'b1;
					end else begin
						sel_d  = SEL_ROM;
						rom_re = 1'b1;
					end
				end else if (is_wr && in_data.region == fcbr_pkg::REG_IO1) begin
					ctrl_d    = in_data.write_data;
					ram_map_d = in_data.write_data[fcbr_pkg::CTRL_RAM_BIT];
					bank_d    = in_data.write_data[fcbr_pkg::CTRL_BANK_LSB +: 2];
					cart_en_d = !in_data.write_data[fcbr_pkg::CTRL_DISABLE_BIT];
					if (in_data.write_data[fcbr_pkg::CTRL_DISABLE_BIT]) begin
						led_d = 1'b0;
					end
				end else if (is_wr && in_data.region == fcbr_pkg::REG_IO2 && ram_map_q) begin
					ram_we    = 1'b1;
					ram_waddr = RAM_AW'(BANK_BYTES - 256) + RAM_AW'(in_data.addr[7:0]);
				end else begin
					served = 1'b0;
				end
			end

			if (!served) begin
				if (in_data.freeze_button && deb_left_q == 20'd0) begin
					deb_left_d = debounce_cycles_q;
					pend_d     = 1'b1;
					nmi_d      = 1'b1;
				end else begin
					if (deb_left_q != 20'd0) begin
						deb_left_d = deb_left_q - 20'd1;
					end
					if (pend_q && run_cnt_d == freeze_write_run_q) begin
						nmi_d     = 1'b0;
						ctrl_d    = fcbr_pkg::CTRL_FROZEN;
						ram_map_d = 1'b0;
						bank_d    = 2'd0;
						cart_en_d = 1'b1;
						pend_d    = 1'b0;
						led_d     = 1'b1;
					end
				end
			end
		end
	end

	fcbr_ram #(
		.WIDTH (8),
		.DEPTH (BANK_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (off),
		.rdata (ram_rdata)
	);

	fcbr_ram #(
		.WIDTH (8),
		.DEPTH (ROM_BYTES)
	) u_rom (
		.clk   (clk),
		.we    (rom_we),
		.waddr (ROM_AW'(load_w)),
		.wdata (in_data.write_data),
		.re    (rom_re),
		.raddr (rom_rd_addr),
		.rdata (rom_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_cycles_q  <= fcbr_pkg::DEBOUNCE_RST;
			freeze_write_run_q <= fcbr_pkg::RUN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcbr_pkg::CFG_DEBOUNCE_CYCLES:  debounce_cycles_q  <= cfg_wdata;
				fcbr_pkg::CFG_FREEZE_WRITE_RUN: freeze_write_run_q <= cfg_wdata[2:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q     <= 8'd0;
			cart_en_q  <= 1'b1;
			ram_map_q  <= 1'b0;
			bank_q     <= 2'd0;
			run_cnt_q  <= 3'd0;
			deb_left_q <= 20'd0;
			pend_q     <= 1'b0;
			nmi_q      <= 1'b0;
			led_q      <= 1'b1;
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
			v_s1       <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			ctrl_q     <= ctrl_d;
			cart_en_q  <= cart_en_d;
			ram_map_q  <= ram_map_d;
			bank_q     <= bank_d;
			run_cnt_q  <= run_cnt_d;
			deb_left_q <= deb_left_d;
			pend_q     <= pend_d;
			nmi_q      <= nmi_d;
			led_q      <= led_d;
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + RAM_AW'(1);
				if (clr_idx_q == RAM_AW'(BANK_BYTES - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_s1  <= sel_d;
			ctrl_s1 <= ctrl_q;
			lvl_s1  <= {ctrl_d[0], ctrl_d[1], nmi_d, led_d};
		end
		if (s1_adv) begin
			out_q.drive_bus <= sel_s1 != SEL_NONE;
			unique case (sel_s1)
				SEL_NONE: out_q.read_data <= 8'd0;
				SEL_ROM:  out_q.read_data <= rom_rdata;
				SEL_RAM:  out_q.read_data <= ram_rdata;
				SEL_CTRL: out_q.read_data <= ctrl_s1;
			endcase
			{out_q.game_low, out_q.exrom_high, out_q.nmi_low, out_q.led_on} <= lvl_s1;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !in_ready)
		else $error("input taken during the RAM clearing pass");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_adv) |=> (v_s1 && $stable(sel_s1) && $stable(ctrl_s1)))
		else $error("read stage lost a stalled item");

	a_enable_matches_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		cart_en_q == !ctrl_q[fcbr_pkg::CTRL_DISABLE_BIT])
		else $error("cartridge enable out of step with the control byte");

	a_nmi_with_pending: assert property (@(posedge clk) disable iff (!arst_n)
		nmi_q == pend_q)
		else $error("NMI level out of step with the pending freeze");

endmodule

`default_nettype wire
